/* design/vwt_pkg.sv */
`timescale 1ns / 1ps
`default_nettype none

package vwt_pkg;

	localparam int TABLE_DEPTH = 1024;
	localparam int ADDR_W      = $clog2(TABLE_DEPTH);
	localparam int CNT_W       = $clog2(TABLE_DEPTH + 1);
	localparam int IDX_W       = 10;
	localparam int COORD_W     = 32;
	localparam int TOL_W       = 31;
	localparam logic [TOL_W-1:0] TOL_RESET = TOL_W'(10);

	typedef struct packed {
		logic signed [COORD_W-1:0] x;
		logic signed [COORD_W-1:0] y;
		logic signed [COORD_W-1:0] z;
	} point_t;

	typedef struct packed {
		logic [IDX_W-1:0] index;
		logic             is_new;
		logic             table_full;
	} result_t;

	// low IDX_W bits of a table index, zero extended when the table is small
	function automatic logic [IDX_W-1:0] to_index(input logic [CNT_W-1:0] v);
		logic [IDX_W+CNT_W-1:0] wide;
		wide = {IDX_W'(0), v};
		return wide[IDX_W-1:0];
	endfunction

endpackage

`default_nettype wire

/* design/vwt_front.sv */
`timescale 1ns / 1ps
`default_nettype none

module vwt_front (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            in_valid,
	output logic            in_ready,
	input  vwt_pkg::point_t in_point,
	output logic            q_valid,
	output vwt_pkg::point_t q_point,
	input  logic            q_pop
);
	import vwt_pkg::*;

	// two-word queue between the input port and the scanner
	point_t     entry_q [2];
	logic [1:0] fill_q;
	logic       wr_ptr_q;
	logic       rd_ptr_q;
	logic       push;
	logic       pop;

	assign in_ready = (fill_q != 2'd2);
	assign q_valid  = (fill_q != 2'd0);
	assign q_point  = entry_q[rd_ptr_q];
	assign push     = in_valid && in_ready;
	assign pop      = q_pop && q_valid;

	always_ff @(posedge clk) begin
		if (push) begin
			entry_q[wr_ptr_q] <= in_point;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fill_q   <= 2'd0;
			wr_ptr_q <= 1'b0;
			rd_ptr_q <= 1'b0;
		end else begin
			if (push) begin
				wr_ptr_q <= ~wr_ptr_q;
			end
			if (pop) begin
				rd_ptr_q <= ~rd_ptr_q;
			end
			if (push && !pop) begin
				fill_q <= fill_q + 2'd1;
			end else if (pop && !push) begin
				fill_q <= fill_q - 2'd1;
			end
		end
	end

endmodule

`default_nettype wire

/* design/vwt_scan.sv */
`timescale 1ns / 1ps
`default_nettype none

module vwt_scan (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic [vwt_pkg::TOL_W-1:0] tol,
	input  logic                      q_valid,
	input  vwt_pkg::point_t           q_point,
	output logic                      q_pop,
	output logic                      out_valid,
	input  logic                      out_ready,
	output vwt_pkg::result_t          out_result
);
	import vwt_pkg::*;

	typedef enum logic {
		S_IDLE,
		S_SCAN
	} state_t;

	function automatic logic axis_close(
		input logic signed [COORD_W-1:0] a,
		input logic signed [COORD_W-1:0] b,
		input logic [TOL_W-1:0]          t
	);
		logic signed [COORD_W:0] d;
		logic signed [COORD_W:0] pos;
		logic signed [COORD_W:0] neg;
		d   = {a[COORD_W-1], a} - {b[COORD_W-1], b};
		pos = {2'b00, t};
		neg = -pos;
		return (d < pos) && (d > neg);
	endfunction

	point_t           mem [TABLE_DEPTH];
	point_t           rd_data_s1;
	logic             data_valid_s1;
	logic [CNT_W-1:0] cmp_idx_s1;

	state_t           state_q;
	point_t           pt_q;
	logic [CNT_W-1:0] count_q;
	logic [CNT_W-1:0] rd_idx_q;
	logic             out_valid_q;
	result_t          out_q;

	logic out_free;
	logic hit;
	logic more;
	logic full;
	logic rd_en;
	logic finish;
	logic wr_en;

	assign out_free = !out_valid_q || out_ready;
	assign hit      = data_valid_s1
		&& axis_close(rd_data_s1.x, pt_q.x, tol)
		&& axis_close(rd_data_s1.y, pt_q.y, tol)
		&& axis_close(rd_data_s1.z, pt_q.z, tol);
	assign more     = rd_idx_q < count_q;
	assign full     = (count_q == CNT_W'(TABLE_DEPTH));
	assign rd_en    = (state_q == S_SCAN) && !hit && more;
	assign finish   = (state_q == S_SCAN) && (hit || !more) && out_free;
	assign wr_en    = finish && !hit && !full;
	assign q_pop    = (state_q == S_IDLE) && q_valid;

	assign out_valid  = out_valid_q;
	assign out_result = out_q;

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[count_q[ADDR_W-1:0]] <= pt_q;
		end
		if (rd_en) begin
			rd_data_s1 <= mem[rd_idx_q[ADDR_W-1:0]];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q       <= S_IDLE;
			pt_q          <= '0;
			count_q       <= '0;
			rd_idx_q      <= '0;
			cmp_idx_s1    <= '0;
			data_valid_s1 <= 1'b0;
			out_valid_q   <= 1'b0;
			out_q         <= '0;
		end else begin
			if (out_valid_q && out_ready) begin
				out_valid_q <= 1'b0;
			end
			unique case (state_q)
				S_IDLE: begin
					if (q_valid) begin
						pt_q          <= q_point;
						rd_idx_q      <= '0;
						data_valid_s1 <= 1'b0;
						state_q       <= S_SCAN;
					end
				end
				S_SCAN: begin
					// a hit waiting on a busy output keeps its compare stage
					if (rd_en || !hit) begin
						data_valid_s1 <= rd_en;
					end
					if (rd_en) begin
						rd_idx_q   <= rd_idx_q + CNT_W'(1);
						cmp_idx_s1 <= rd_idx_q;
					end
					if (finish) begin
						state_q     <= S_IDLE;
						out_valid_q <= 1'b1;
						if (hit) begin
							out_q.index      <= to_index(cmp_idx_s1);
							out_q.is_new     <= 1'b0;
							out_q.table_full <= 1'b0;
						end else if (full) begin
							out_q.index      <= '0;
							out_q.is_new     <= 1'b0;
							out_q.table_full <= 1'b1;
						end else begin
							out_q.index      <= to_index(count_q);
							out_q.is_new     <= 1'b1;
							out_q.table_full <= 1'b0;
							count_q          <= count_q + CNT_W'(1);
						end
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

endmodule

`default_nettype wire

/* design/vertex_weld_table.sv */
`timescale 1ns / 1ps
`default_nettype none

// Vertex weld table: each input word is a signed Q12.20 point; the stored points are
// scanned in insertion order for the first one within match_tolerance (strict, per axis).
// A hit returns its index; otherwise the point is appended and its new index returned with
// is_new, or table_full is returned when all TABLE_DEPTH entries are used. One scanner with
// a single memory read port checks one stored entry per cycle, up to the first hit (all
// stored entries on a miss, at most TABLE_DEPTH). A two-word input queue and an output
// register let the port sides stall independently. The table is empty after reset; no
// clearing pass.
module vertex_weld_table (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      psel,
	input  logic                      penable,
	input  logic                      pwrite,
	input  logic [2:0]                paddr,
	input  logic [31:0]               pwdata,
	output logic [31:0]               prdata,
	output logic                      pready,
	input  logic                      in_valid,
	output logic                      in_ready,
	input  logic signed [31:0]        point_x,
	input  logic signed [31:0]        point_y,
	input  logic signed [31:0]        point_z,
	output logic                      out_valid,
	input  logic                      out_ready,
	output logic [vwt_pkg::IDX_W-1:0] point_index,
	output logic                      is_new,
	output logic                      table_full
);
	import vwt_pkg::*;

	localparam logic REG_MATCH_TOLERANCE = 1'b0;

	logic [TOL_W-1:0] tol_q;
	point_t           in_point;
	logic             q_valid;
	point_t           q_point;
	logic             q_pop;
	result_t          result;

	assign pready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tol_q <= TOL_RESET;
		end else if (psel && penable && pwrite && pready
			&& (paddr[2] == REG_MATCH_TOLERANCE)) begin
			tol_q <= pwdata[TOL_W-1:0];
		end
	end

	always_comb begin
		prdata = '0;
		if (paddr[2] == REG_MATCH_TOLERANCE) begin
			prdata = {1'b0, tol_q};
		end
	end

	assign in_point.x = point_x;
	assign in_point.y = point_y;
	assign in_point.z = point_z;

	vwt_front u_front (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_ready (in_ready),
		.in_point (in_point),
		.q_valid  (q_valid),
		.q_point  (q_point),
		.q_pop    (q_pop)
	);

	vwt_scan u_scan (
		.clk        (clk),
		.arst_n     (arst_n),
		.tol        (tol_q),
		.q_valid    (q_valid),
		.q_point    (q_point),
		.q_pop      (q_pop),
		.out_valid  (out_valid),
		.out_ready  (out_ready),
		.out_result (result)
	);

	assign point_index = result.index;
	assign is_new      = result.is_new;
	assign table_full  = result.table_full;

endmodule

`default_nettype wire

/* verif/testbench.sv */
`timescale 1ns / 1ps

module testbench;
	import vwt_pkg::*;

	localparam logic [2:0] TOL_ADDR   = 3'd0;
	localparam logic [2:0] SPARE_ADDR = 3'd4;
	localparam int unsigned QUIET_LIMIT = 20000;
	localparam int SETTLE_CYCLES = TABLE_DEPTH + 64;
	localparam logic signed [COORD_W-1:0] C_MAX = 32'sh7FFF_FFFF;
	localparam logic signed [COORD_W-1:0] C_MIN = 32'sh8000_0000;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic psel = 1'b0;
	logic penable = 1'b0;
	logic pwrite = 1'b0;
	logic [2:0] paddr = '0;
	logic [31:0] pwdata = '0;
	logic [31:0] prdata;
	logic pready;
	logic in_valid = 1'b0;
	logic in_ready;
	logic signed [COORD_W-1:0] point_x = '0;
	logic signed [COORD_W-1:0] point_y = '0;
	logic signed [COORD_W-1:0] point_z = '0;
	logic out_valid;
	logic out_ready = 1'b0;
	logic [IDX_W-1:0] point_index;
	logic is_new;
	logic table_full;

	vertex_weld_table u_dut (
		.clk(clk),
		.arst_n(arst_n),
		.psel(psel),
		.penable(penable),
		.pwrite(pwrite),
		.paddr(paddr),
		.pwdata(pwdata),
		.prdata(prdata),
		.pready(pready),
		.in_valid(in_valid),
		.in_ready(in_ready),
		.point_x(point_x),
		.point_y(point_y),
		.point_z(point_z),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.point_index(point_index),
		.is_new(is_new),
		.table_full(table_full)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	logic signed [COORD_W-1:0] known_x [TABLE_DEPTH];
	logic signed [COORD_W-1:0] known_y [TABLE_DEPTH];
	logic signed [COORD_W-1:0] known_z [TABLE_DEPTH];
	int known_count = 0;
	logic [TOL_W-1:0] weld_tol = TOL_RESET;

	result_t welds_due[$];
	int errors = 0;
	bit in_held = 1'b0;
	bit tx_idle_on = 1'b1;
	bit rx_idle_on = 1'b1;
	int unsigned hold_len = 0;
	int unsigned quiet_cycles = 0;

	function automatic bit axis_near(input logic signed [COORD_W-1:0] a,
			input logic signed [COORD_W-1:0] b);
		longint d;
		d = longint'(a) - longint'(b);
		if (d < 0) begin
			d = -d;
		end
		return d < longint'({1'b0, weld_tol});
	endfunction

	// first stored point within tolerance, else append, else full
	function automatic result_t weld_point(input point_t p);
		result_t res;
		res = '0;
		for (int i = 0; i < known_count; i++) begin
			if (axis_near(known_x[i], p.x) && axis_near(known_y[i], p.y) &&
					axis_near(known_z[i], p.z)) begin
				res.index = IDX_W'(i);
				return res;
			end
		end
		if (known_count >= TABLE_DEPTH) begin
			res.table_full = 1'b1;
			return res;
		end
		known_x[known_count] = p.x;
		known_y[known_count] = p.y;
		known_z[known_count] = p.z;
		res.index = IDX_W'(known_count);
		res.is_new = 1'b1;
		known_count++;
		return res;
	endfunction

	function automatic logic signed [COORD_W-1:0] nudge(input logic signed [COORD_W-1:0] base,
			input longint span);
		longint unsigned r;
		longint v;
		r = {$urandom, $urandom};
		v = longint'(base) + longint'(r % longint'(2 * span + 1)) - span;
		if (v > longint'(C_MAX)) begin
			v = longint'(C_MAX);
		end
		if (v < longint'(C_MIN)) begin
			v = longint'(C_MIN);
		end
		return v[COORD_W-1:0];
	endfunction

	function automatic point_t near_point(input longint span);
		point_t p;
		int k;
		k = $urandom_range(0, known_count - 1);
		p.x = nudge(known_x[k], span);
		p.y = nudge(known_y[k], span);
		p.z = nudge(known_z[k], span);
		return p;
	endfunction

	function automatic point_t fresh_point();
		point_t p;
		p.x = $urandom;
		p.y = $urandom;
		p.z = $urandom;
		return p;
	endfunction

	function automatic point_t mk_point(input logic signed [COORD_W-1:0] x,
			input logic signed [COORD_W-1:0] y, input logic signed [COORD_W-1:0] z);
		point_t p;
		p.x = x;
		p.y = y;
		p.z = z;
		return p;
	endfunction

	// in_valid stays high after acceptance so back-to-back words need no drop
	task automatic offer_point(input point_t p);
		int unsigned gap;
		gap = tx_idle_on ? $urandom_range(0, 15) : 0;
		if (gap != 0 && in_held) begin
			in_valid <= 1'b0;
			in_held = 1'b0;
		end
		repeat (gap) @(posedge clk);
		point_x <= p.x;
		point_y <= p.y;
		point_z <= p.z;
		in_valid <= 1'b1;
		in_held = 1'b1;
		do @(posedge clk); while (!in_ready);
		welds_due.push_back(weld_point(p));
	endtask

	task automatic in_idle();
		if (in_held) begin
			in_valid <= 1'b0;
			in_held = 1'b0;
			@(posedge clk);
		end
	endtask

	task automatic drain();
		while (welds_due.size() != 0) @(posedge clk);
	endtask

	task automatic apb_access(input logic write, input logic [2:0] addr,
			input logic [31:0] wdata, output logic [31:0] rdata);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= write;
		paddr <= addr;
		pwdata <= wdata;
		@(posedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (!pready);
		rdata = prdata;
		psel <= 1'b0;
		penable <= 1'b0;
		if (write && addr == TOL_ADDR) begin
			weld_tol = wdata[TOL_W-1:0];
		end
		@(posedge clk);
	endtask

	task automatic tolerance_readback();
		logic [31:0] rd;
		apb_access(1'b0, TOL_ADDR, 32'h0, rd);
		if (rd !== {1'b0, weld_tol}) begin
			$display("%0t match_tolerance read expected %0h actual %0h",
				$time, {1'b0, weld_tol}, rd);
			errors++;
		end
	endtask

	task automatic set_tolerance(input logic [31:0] value);
		logic [31:0] rd;
		in_idle();
		drain();
		apb_access(1'b1, TOL_ADDR, value, rd);
		tolerance_readback();
	endtask

	task automatic test_tolerance_edges();
		in_idle();
		drain();
		tolerance_readback();
		offer_point(mk_point(0, 0, 0));
		offer_point(mk_point(9, -9, 9));
		offer_point(mk_point(10, 0, 0));
		offer_point(mk_point(0, -10, 0));
		offer_point(mk_point(19, 0, 0));
		offer_point(mk_point(5, -5, 0));
		in_idle();
	endtask

	// differences up to 2^32 - 1 against the widest tolerance
	task automatic test_coordinate_extremes();
		set_tolerance(32'hFFFF_FFFF);
		offer_point(mk_point(C_MAX, C_MAX, C_MAX));
		offer_point(mk_point(C_MIN, C_MIN, C_MIN));
		offer_point(mk_point(C_MAX, C_MIN, C_MAX));
		offer_point(mk_point(C_MIN, C_MAX, C_MIN));
		offer_point(mk_point(-1, -1, -1));
		offer_point(mk_point(C_MAX, 0, C_MIN));
		offer_point(mk_point(C_MIN + 1, C_MAX - 1, 1));
		in_idle();
	endtask

	task automatic test_zero_tolerance();
		set_tolerance(32'h0);
		offer_point(mk_point(0, 0, 0));
		offer_point(mk_point(0, 0, 0));
		offer_point(mk_point(C_MAX, C_MAX, C_MAX));
		in_idle();
	endtask

	task automatic test_spare_register();
		logic [31:0] rd;
		set_tolerance(32'd1000);
		apb_access(1'b1, SPARE_ADDR, 32'h0, rd);
		tolerance_readback();
		offer_point(mk_point(500, -500, 999));
		offer_point(mk_point(1000, 0, 0));
		in_idle();
	endtask

	task automatic test_random_welding();
		logic [31:0] tols [8];
		int unsigned r;
		longint tol;
		point_t p;
		tols = '{32'd1, 32'd7, 32'd10, 32'd300, 32'd65536, 32'd0, 32'h7FFF_FFFF, 32'd3};
		tols[5] = $urandom_range(1, 1 << 22);
		for (int ph = 0; ph < 8; ph++) begin
			set_tolerance(tols[ph]);
			tx_idle_on = (ph % 4 != 1) && (ph % 4 != 3);
			rx_idle_on = (ph % 4 != 2) && (ph % 4 != 3);
			tol = longint'({1'b0, weld_tol});
			for (int n = 0; n < 68; n++) begin
				r = $urandom_range(0, 99);
				if (known_count == 0 || r < 20) begin
					p = fresh_point();
				end else if (r < 80) begin
					p = near_point(tol - 1);
				end else begin
					p = near_point(2 * tol);
				end
				if ($urandom_range(0, 39) == 0) begin
					in_idle();
					drain();
				end
				offer_point(p);
			end
		end
		in_idle();
		tx_idle_on = 1'b1;
		rx_idle_on = 1'b1;
	endtask

	task automatic test_backpressure();
		in_idle();
		drain();
		tx_idle_on = 1'b0;
		hold_len = 400;
		for (int n = 0; n < 16; n++) begin
			offer_point(near_point(0));
		end
		in_idle();
		drain();
		tx_idle_on = 1'b1;
	endtask

	initial begin
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_tolerance_edges();
		test_coordinate_extremes();
		test_zero_tolerance();
		test_spare_register();
		test_random_welding();
		test_backpressure();
		in_idle();
		drain();
		repeat (SETTLE_CYCLES) @(posedge clk);
		if (errors == 0) begin
			$display("testbench OK");
		end else begin
			$display("testbench NOT OK");
		end
		$finish;
	end

	// receiver: optional long hold-off, then, when rx_idle_on, a random stall before each result word
	initial begin : result_sink
		int unsigned stall;
		forever begin
			if (hold_len != 0) begin
				out_ready <= 1'b0;
				repeat (hold_len) @(posedge clk);
				hold_len = 0;
			end
			stall = rx_idle_on ? $urandom_range(0, 15) : 0;
			if (stall != 0) begin
				out_ready <= 1'b0;
				repeat (stall) @(posedge clk);
			end
			out_ready <= 1'b1;
			do @(posedge clk); while (!out_valid);
		end
	end

	always @(posedge clk) begin : result_check
		result_t want;
		if (arst_n && out_valid && out_ready) begin
			if (welds_due.size() == 0) begin
				$display("%0t unexpected result expected none actual index=%0d new=%0d full=%0d",
					$time, point_index, is_new, table_full);
				errors++;
			end else begin
				want = welds_due.pop_front();
				if (point_index !== want.index) begin
					$display("%0t point_index expected %0d actual %0d",
						$time, want.index, point_index);
					errors++;
				end
				if (is_new !== want.is_new) begin
					$display("%0t is_new expected %0d actual %0d", $time, want.is_new, is_new);
					errors++;
				end
				if (table_full !== want.table_full) begin
					$display("%0t table_full expected %0d actual %0d",
						$time, want.table_full, table_full);
					errors++;
				end
			end
		end
	end

	always @(posedge clk) begin
		if (!arst_n || psel || (in_valid && in_ready) || (out_valid && out_ready)) begin
			quiet_cycles <= 0;
		end else if (quiet_cycles >= QUIET_LIMIT) begin
			$display("%0t no word moved for %0d cycles", $time, quiet_cycles);
			$display("testbench NOT OK");
			$finish;
		end else begin
			quiet_cycles <= quiet_cycles + 1;
		end
	end

endmodule

/* vertex_weld_table.f */
design/vwt_pkg.sv
design/vwt_front.sv
design/vwt_scan.sv
design/vertex_weld_table.sv
verif/testbench.sv
